// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/rlrc_pkg.sv -----
// package with the state, event, action and register codes of the retry controller
`default_nettype none

package rlrc_pkg;

    // controller states
    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_WAIT_ACK  = 3'd2;
    localparam logic [2:0] ST_GET_DATA  = 3'd3;
    localparam logic [2:0] ST_LINK_TEST = 3'd4;

    // event kinds
    localparam logic [2:0] EV_INIT       = 3'd0;
    localparam logic [2:0] EV_TX_REQ     = 3'd1;
    localparam logic [2:0] EV_LINK_SETUP = 3'd2;
    localparam logic [2:0] EV_RX         = 3'd3;
    localparam logic [2:0] EV_TIMEOUT    = 3'd4;
    localparam logic [2:0] EV_END_LINK   = 3'd5;

    // action codes
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_SEND   = 3'd1;
    localparam logic [2:0] ACT_RESEND = 3'd2;
    localparam logic [2:0] ACT_ACK    = 3'd3;
    localparam logic [2:0] ACT_NACK   = 3'd4;
    localparam logic [2:0] ACT_PONG   = 3'd5;
    localparam logic [2:0] ACT_RELAY  = 3'd6;
    localparam logic [2:0] ACT_FAIL   = 3'd7;

    // register indexes
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd0;
    localparam logic [2:0] REG_SHORT_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_LONG_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_ID_DATA_FIRST = 3'd3;
    localparam logic [2:0] REG_ID_DATA_NEXT  = 3'd4;
    localparam logic [2:0] REG_ID_PING       = 3'd5;

    // register reset values
    localparam logic [3:0]  RST_RETRY_LIMIT   = 4'd2;
    localparam logic [15:0] RST_SHORT_TIMEOUT = 16'd250;
    localparam logic [15:0] RST_LONG_TIMEOUT  = 16'd1700;
    localparam logic [7:0]  RST_ID_DATA_FIRST = 8'd16;
    localparam logic [7:0]  RST_ID_DATA_NEXT  = 8'd17;
    localparam logic [7:0]  RST_ID_PING       = 8'd32;

    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    // one result of the controller
    typedef struct packed {
        logic [2:0]  action;
        logic        timer_start;
        logic [15:0] timer_period_ms;
        logic        listening;
        logic [2:0]  fsm_state;
        logic [3:0]  retry_count;
        logic [15:0] retry_total;
    } result_t;

endpackage

`default_nettype wire

// ----- src/radio_link_retry_controller_top.sv -----
// top level of the stop-and-wait radio link retry controller
// Usage
//   input channel (in_valid/in_ready): one event per request, with its packet bytes.
//   output channel (out_valid/out_ready): exactly one result per event: action,
//   timer start and period, listening flag, state and retry counters after the event.
//   config port: apb-style, registers at byte addresses 4*i, pready always high;
//   write only while no event is in flight.
// Result timing and throughput
//   the result of an event is in the output register in the cycle after acceptance.
//   one event per cycle is sustained while out_ready is high: the next-state and action
//   logic is a single combinational pass from the controller state into the output register.
// Reset
//   rst_n clears the output register and puts the controller in its init state
//   with zero counters; registers take their reset values.
// Stalls
//   while a result waits with out_ready low, in_ready is low; when the waiting
//   result is taken, a new event is accepted in that same cycle.
`default_nettype none

`include "assert_macros.svh"

module radio_link_retry_controller_top
    import rlrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // event channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  event_kind,
    input  wire logic        is_data_request,
    input  wire logic [7:0]  rx_message_id,
    input  wire logic [7:0]  rx_byte_one,
    input  wire logic [7:0]  rx_byte_two,
    input  wire logic [7:0]  rx_byte_ten,
    input  wire logic [7:0]  rx_byte_eleven,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  action,
    output logic             timer_start,
    output logic      [15:0] timer_period_ms,
    output logic             listening,
    output logic      [2:0]  fsm_state_out,
    output logic      [3:0]  retry_count_out,
    output logic      [15:0] total_retries_out
);

    logic [3:0]  retry_limit_reg;
    logic [15:0] short_timeout_reg;
    logic [15:0] long_timeout_reg;
    logic [7:0]  id_data_first_reg;
    logic [7:0]  id_data_next_reg;
    logic [7:0]  id_ping_reg;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  retry_reg, retry_next;
    logic [15:0] total_reg, total_next;
    logic        listen_reg, listen_next;

    logic        out_valid_reg;
    result_t     res_reg, res_next;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        in_take;

    // config write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= RST_RETRY_LIMIT;
            short_timeout_reg <= RST_SHORT_TIMEOUT;
            long_timeout_reg  <= RST_LONG_TIMEOUT;
            id_data_first_reg <= RST_ID_DATA_FIRST;
            id_data_next_reg  <= RST_ID_DATA_NEXT;
            id_ping_reg       <= RST_ID_PING;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RETRY_LIMIT:   retry_limit_reg   <= pwdata[3:0];
                REG_SHORT_TIMEOUT: short_timeout_reg <= pwdata[15:0];
                REG_LONG_TIMEOUT:  long_timeout_reg  <= pwdata[15:0];
                REG_ID_DATA_FIRST: id_data_first_reg <= pwdata[7:0];
                REG_ID_DATA_NEXT:  id_data_next_reg  <= pwdata[7:0];
                REG_ID_PING:       id_ping_reg       <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RETRY_LIMIT:   prdata = {28'd0, retry_limit_reg};
            REG_SHORT_TIMEOUT: prdata = {16'd0, short_timeout_reg};
            REG_LONG_TIMEOUT:  prdata = {16'd0, long_timeout_reg};
            REG_ID_DATA_FIRST: prdata = {24'd0, id_data_first_reg};
            REG_ID_DATA_NEXT:  prdata = {24'd0, id_data_next_reg};
            REG_ID_PING:       prdata = {24'd0, id_ping_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // handshake: accept whenever the output register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    // next state and result for one event
    always_comb
    begin
        logic        known;
        logic [7:0]  pkt_total;
        logic [7:0]  pkt_cur;
        logic [2:0]  act;
        logic        tstart;
        logic [15:0] period;
        logic        bump;

        state_next  = state_reg;
        retry_next  = retry_reg;
        total_next  = total_reg;
        listen_next = listen_reg;
        act         = ACT_NONE;
        tstart      = 1'b0;
        period      = 16'd0;
        bump        = 1'b0;

        // first id wins when both data ids match
        known     = 1'b1;
        pkt_total = rx_byte_ten;
        pkt_cur   = rx_byte_eleven;
        if (rx_message_id == id_data_first_reg)
        begin
            pkt_total = rx_byte_ten;
            pkt_cur   = rx_byte_eleven;
        end
        else if (rx_message_id == id_data_next_reg)
        begin
            pkt_total = rx_byte_one;
            pkt_cur   = rx_byte_two;
        end
        else
        begin
            known = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                if (event_kind == EV_INIT)
                begin
                    retry_next  = 4'd0;
                    total_next  = 16'd0;
                    listen_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (event_kind == EV_TX_REQ)
                begin
                    act         = ACT_SEND;
                    listen_next = 1'b1;
                    tstart      = 1'b1;
                    retry_next  = 4'd0;
                    if (is_data_request)
                    begin
                        period     = long_timeout_reg;
                        state_next = ST_GET_DATA;
                    end
                    else
                    begin
                        period     = short_timeout_reg;
                        state_next = ST_WAIT_ACK;
                    end
                end
                else if (event_kind == EV_LINK_SETUP)
                begin
                    listen_next = 1'b1;
                    state_next  = ST_LINK_TEST;
                end
            end
            ST_WAIT_ACK:
            begin
                if (event_kind == EV_RX)
                begin
                    // any reply is relayed, retry count kept
                    act         = ACT_RELAY;
                    state_next  = ST_IDLE;
                    listen_next = 1'b0;
                end
                else if (event_kind == EV_TIMEOUT)
                begin
                    if (retry_reg < retry_limit_reg)
                    begin
                        act         = ACT_RESEND;
                        listen_next = 1'b1;
                        tstart      = 1'b1;
                        period      = short_timeout_reg;
                        bump        = 1'b1;
                    end
                    else
                    begin
                        act         = ACT_FAIL;
                        retry_next  = 4'd0;
                        state_next  = ST_IDLE;
                        listen_next = 1'b0;
                    end
                end
            end
            ST_GET_DATA:
            begin
                if (event_kind == EV_RX)
                begin
                    if (!known)
                    begin
                        act         = ACT_FAIL;
                        retry_next  = 4'd0;
                        state_next  = ST_IDLE;
                        listen_next = 1'b0;
                    end
                    else if (pkt_total == pkt_cur)
                    begin
                        // last packet: back to idle without an ack
                        retry_next  = 4'd0;
                        state_next  = ST_IDLE;
                        listen_next = 1'b0;
                    end
                    else
                    begin
                        act         = ACT_ACK;
                        listen_next = 1'b1;
                        tstart      = 1'b1;
                        period      = long_timeout_reg;
                        retry_next  = 4'd0;
                    end
                end
                else if (event_kind == EV_TIMEOUT)
                begin
                    if (retry_reg < retry_limit_reg)
                    begin
                        act         = ACT_NACK;
                        listen_next = 1'b1;
                        tstart      = 1'b1;
                        period      = long_timeout_reg;
                        bump        = 1'b1;
                    end
                    else
                    begin
                        act         = ACT_FAIL;
                        retry_next  = 4'd0;
                        state_next  = ST_IDLE;
                        listen_next = 1'b0;
                    end
                end
            end
            ST_LINK_TEST:
            begin
                if (event_kind == EV_RX)
                begin
                    if (rx_message_id == id_ping_reg)
                    begin
                        act = ACT_PONG;
                    end
                end
                else if (event_kind == EV_END_LINK)
                begin
                    state_next  = ST_IDLE;
                    listen_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // retry counters, total saturates
        if (bump)
        begin
            retry_next = retry_reg + 4'd1;
            if (total_reg != TOTAL_MAX)
            begin
                total_next = total_reg + 16'd1;
            end
        end

        res_next.action          = act;
        res_next.timer_start     = tstart;
        res_next.timer_period_ms = period;
        res_next.listening       = listen_next;
        res_next.fsm_state       = state_next;
        res_next.retry_count     = retry_next;
        res_next.retry_total     = total_next;
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            retry_reg  <= 4'd0;
            total_reg  <= 16'd0;
            listen_reg <= 1'b0;
        end
        else if (in_take)
        begin
            state_reg  <= state_next;
            retry_reg  <= retry_next;
            total_reg  <= total_next;
            listen_reg <= listen_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (in_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign action            = res_reg.action;
    assign timer_start       = res_reg.timer_start;
    assign timer_period_ms   = res_reg.timer_period_ms;
    assign listening         = res_reg.listening;
    assign fsm_state_out     = res_reg.fsm_state;
    assign retry_count_out   = res_reg.retry_count;
    assign total_retries_out = res_reg.retry_total;

    // checks
    `ASSERT_IMP(a_retry_nonzero, clk, rst_n, out_valid && (action == ACT_RESEND || action == ACT_NACK), retry_count_out != 4'd0)
    `ASSERT_IMP(a_fail_to_idle, clk, rst_n, out_valid && action == ACT_FAIL, fsm_state_out == ST_IDLE && !listening)
    `ASSERT_IMP(a_timer_listen, clk, rst_n, out_valid && timer_start, listening)
    `ASSERT_NXT(a_init_leaves, clk, rst_n, in_take && state_reg == ST_INIT && event_kind == EV_INIT, out_valid && fsm_state_out == ST_IDLE && total_retries_out == 16'd0)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the stop-and-wait radio link retry controller
module tb_top
    import rlrc_pkg::*;
();

    // event kinds with no meaning anywhere
    localparam logic [2:0] EV_UNUSED_SIX   = 3'd6;
    localparam logic [2:0] EV_UNUSED_SEVEN = 3'd7;

    // one event request with its packet bytes
    typedef struct packed {
        logic [2:0] kind;
        logic       data_req;
        logic [7:0] msg_id;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_ten;
        logic [7:0] byte_eleven;
    } event_t;

    // retry controller mirror: tracks state and config, queues the expected results
    class link_event_checker;
        logic [3:0]  retry_limit;
        logic [15:0] short_period;
        logic [15:0] long_period;
        logic [7:0]  first_id;
        logic [7:0]  next_id;
        logic [7:0]  ping_id;
        logic [2:0]  state;
        logic [3:0]  retries;
        logic [15:0] retry_total;
        logic        listen;
        result_t     expected_results[$];
        int          error_count;

        function new();
            retry_limit   = RST_RETRY_LIMIT;
            short_period  = RST_SHORT_TIMEOUT;
            long_period   = RST_LONG_TIMEOUT;
            first_id      = RST_ID_DATA_FIRST;
            next_id       = RST_ID_DATA_NEXT;
            ping_id       = RST_ID_PING;
            state         = ST_INIT;
            retries       = '0;
            retry_total   = '0;
            listen        = 1'b0;
            error_count   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_RETRY_LIMIT:   retry_limit  = value[3:0];
                REG_SHORT_TIMEOUT: short_period = value[15:0];
                REG_LONG_TIMEOUT:  long_period  = value[15:0];
                REG_ID_DATA_FIRST: first_id     = value[7:0];
                REG_ID_DATA_NEXT:  next_id      = value[7:0];
                REG_ID_PING:       ping_id      = value[7:0];
                default:           ;
            endcase
        endfunction

        // return to idle; leaving a data transfer also clears the retry count
        function void enter_idle();
            if (state == ST_GET_DATA)
                retries = '0;
            state  = ST_IDLE;
            listen = 1'b0;
        endfunction

        function void bump_retry();
            retries = retries + 4'd1;
            if (retry_total != TOTAL_MAX)
                retry_total = retry_total + 16'd1;
        endfunction

        // predict the result of an accepted event; returns 1 if it had any effect
        function bit note_event(event_t e);
            result_t    r;
            logic [2:0] prior_state;
            logic [7:0] pkt_total;
            logic [7:0] pkt_number;
            bit         known;
            prior_state = state;
            r = '0;
            r.action = ACT_NONE;
            pkt_total = '0;
            pkt_number = '0;
            case (state)
                ST_INIT:
                begin
                    if (e.kind == EV_INIT)
                    begin
                        retries = '0;
                        retry_total = '0;
                        enter_idle();
                    end
                end
                ST_IDLE:
                begin
                    if (e.kind == EV_TX_REQ)
                    begin
                        r.action = ACT_SEND;
                        r.timer_start = 1'b1;
                        listen = 1'b1;
                        retries = '0;
                        if (e.data_req)
                        begin
                            r.timer_period_ms = long_period;
                            state = ST_GET_DATA;
                        end
                        else
                        begin
                            r.timer_period_ms = short_period;
                            state = ST_WAIT_ACK;
                        end
                    end
                    else if (e.kind == EV_LINK_SETUP)
                    begin
                        listen = 1'b1;
                        state = ST_LINK_TEST;
                    end
                end
                ST_WAIT_ACK:
                begin
                    if (e.kind == EV_RX)
                    begin
                        r.action = ACT_RELAY;
                        enter_idle();
                    end
                    else if (e.kind == EV_TIMEOUT)
                    begin
                        if (retries < retry_limit)
                        begin
                            r.action = ACT_RESEND;
                            r.timer_start = 1'b1;
                            r.timer_period_ms = short_period;
                            listen = 1'b1;
                            bump_retry();
                        end
                        else
                        begin
                            r.action = ACT_FAIL;
                            retries = '0;
                            enter_idle();
                        end
                    end
                end
                ST_GET_DATA:
                begin
                    if (e.kind == EV_RX)
                    begin
                        // first-packet id wins when both ids are equal
                        known = 1'b1;
                        if (e.msg_id == first_id)
                        begin
                            pkt_total = e.byte_ten;
                            pkt_number = e.byte_eleven;
                        end
                        else if (e.msg_id == next_id)
                        begin
                            pkt_total = e.byte_one;
                            pkt_number = e.byte_two;
                        end
                        else
                            known = 1'b0;
                        if (!known)
                        begin
                            r.action = ACT_FAIL;
                            enter_idle();
                        end
                        else if (pkt_total == pkt_number)
                            enter_idle();
                        else
                        begin
                            r.action = ACT_ACK;
                            r.timer_start = 1'b1;
                            r.timer_period_ms = long_period;
                            listen = 1'b1;
                            retries = '0;
                        end
                    end
                    else if (e.kind == EV_TIMEOUT)
                    begin
                        if (retries < retry_limit)
                        begin
                            r.action = ACT_NACK;
                            r.timer_start = 1'b1;
                            r.timer_period_ms = long_period;
                            listen = 1'b1;
                            bump_retry();
                        end
                        else
                        begin
                            r.action = ACT_FAIL;
                            enter_idle();
                        end
                    end
                end
                ST_LINK_TEST:
                begin
                    if (e.kind == EV_RX)
                    begin
                        if (e.msg_id == ping_id)
                            r.action = ACT_PONG;
                    end
                    else if (e.kind == EV_END_LINK)
                        enter_idle();
                end
                default: ;
            endcase
            r.listening     = listen;
            r.fsm_state     = state;
            r.retry_count   = retries;
            r.retry_total   = retry_total;
            expected_results.push_back(r);
            return (r.action != ACT_NONE) || (state != prior_state);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, seen);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no pending event: action %0d state %0d",
                       got.action, got.fsm_state);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("action", 16'(want.action), 16'(got.action));
            compare_field("timer_start", 16'(want.timer_start), 16'(got.timer_start));
            compare_field("timer_period_ms", want.timer_period_ms, got.timer_period_ms);
            compare_field("listening", 16'(want.listening), 16'(got.listening));
            compare_field("fsm_state_out", 16'(want.fsm_state), 16'(got.fsm_state));
            compare_field("retry_count_out", 16'(want.retry_count), 16'(got.retry_count));
            compare_field("total_retries_out", want.retry_total, got.retry_total);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  event_kind;
    logic        is_data_request;
    logic [7:0]  rx_message_id;
    logic [7:0]  rx_byte_one;
    logic [7:0]  rx_byte_two;
    logic [7:0]  rx_byte_ten;
    logic [7:0]  rx_byte_eleven;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic        timer_start;
    logic [15:0] timer_period_ms;
    logic        listening;
    logic [2:0]  fsm_state_out;
    logic [3:0]  retry_count_out;
    logic [15:0] total_retries_out;

    link_event_checker board = new();
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    bit hold_request    = 1'b0;

    radio_link_retry_controller_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .event_kind        (event_kind),
        .is_data_request   (is_data_request),
        .rx_message_id     (rx_message_id),
        .rx_byte_one       (rx_byte_one),
        .rx_byte_two       (rx_byte_two),
        .rx_byte_ten       (rx_byte_ten),
        .rx_byte_eleven    (rx_byte_eleven),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .action            (action),
        .timer_start       (timer_start),
        .timer_period_ms   (timer_period_ms),
        .listening         (listening),
        .fsm_state_out     (fsm_state_out),
        .retry_count_out   (retry_count_out),
        .total_retries_out (total_retries_out)
    );

    // clock
    always #4 clk = ~clk;

    // result sink: random stalls, plus a long hold-off counted here on request
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // results are sampled mid-cycle, where inputs and outputs are settled
    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result(result_t'({action, timer_start, timer_period_ms, listening,
                                          fsm_state_out, retry_count_out,
                                          total_retries_out}));

    function automatic event_t make_event(logic [2:0] kind, logic data_req, logic [7:0] id,
                                          logic [7:0] b1, logic [7:0] b2,
                                          logic [7:0] b10, logic [7:0] b11);
        event_t e;
        e.kind        = kind;
        e.data_req    = data_req;
        e.msg_id      = id;
        e.byte_one    = b1;
        e.byte_two    = b2;
        e.byte_ten    = b10;
        e.byte_eleven = b11;
        return e;
    endfunction

    // random request, mostly one that makes sense in the tracked state
    function automatic event_t draw_event();
        event_t     e;
        int         roll;
        int         pick;
        logic [7:0] pkt_total;
        logic [7:0] pkt_number;
        e = make_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return e;
        pkt_total = 8'($urandom_range(0, 255));
        pkt_number = ($urandom_range(0, 3) == 0) ? pkt_total : 8'($urandom_range(0, 255));
        case (board.state)
            ST_IDLE:
                e.kind = (roll < 75) ? EV_TX_REQ : EV_LINK_SETUP;
            ST_WAIT_ACK:
                e.kind = (roll < 75) ? EV_TIMEOUT : EV_RX;
            ST_GET_DATA:
            begin
                if (roll < 40)
                    e.kind = EV_TIMEOUT;
                else
                begin
                    e.kind = EV_RX;
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        e.msg_id = board.first_id;
                        e.byte_ten = pkt_total;
                        e.byte_eleven = pkt_number;
                    end
                    else if (pick < 9)
                    begin
                        e.msg_id = board.next_id;
                        e.byte_one = pkt_total;
                        e.byte_two = pkt_number;
                    end
                end
            end
            ST_LINK_TEST:
            begin
                if (roll < 80)
                begin
                    e.kind = EV_RX;
                    if ($urandom_range(0, 1) == 1)
                        e.msg_id = board.ping_id;
                end
                else
                    e.kind = EV_END_LINK;
            end
            default:
                e.kind = EV_INIT;
        endcase
        return e;
    endfunction

    // offer one request and hold it until taken; reports whether it had any effect
    task automatic offer_event(input event_t e, output bit effect);
        bit taken;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        event_kind      <= e.kind;
        is_data_request <= e.data_req;
        rx_message_id   <= e.msg_id;
        rx_byte_one     <= e.byte_one;
        rx_byte_two     <= e.byte_two;
        rx_byte_ten     <= e.byte_ten;
        rx_byte_eleven  <= e.byte_eleven;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_valid && in_ready;
            @(posedge clk);
        end
        effect = board.note_event(e);
    endtask

    task automatic wait_drained();
        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    // reprogram every register once the controller has gone quiet
    task automatic program_regs(input logic [3:0] limit, input logic [15:0] short_ms,
                                input logic [15:0] long_ms, input logic [7:0] first,
                                input logic [7:0] next, input logic [7:0] ping);
        wait_drained();
        apb_write(REG_RETRY_LIMIT, {28'd0, limit});
        apb_write(REG_SHORT_TIMEOUT, {16'd0, short_ms});
        apb_write(REG_LONG_TIMEOUT, {16'd0, long_ms});
        apb_write(REG_ID_DATA_FIRST, {24'd0, first});
        apb_write(REG_ID_DATA_NEXT, {24'd0, next});
        apb_write(REG_ID_PING, {24'd0, ping});
    endtask

    // random requests until enough of them had an effect
    task automatic run_phase(input int target, input int idle_pct, input int stall_pct);
        int useful;
        bit effect;
        sender_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        useful = 0;
        while (useful < target)
        begin
            offer_event(draw_event(), effect);
            if (effect)
                useful++;
        end
        in_valid <= 1'b0;
    endtask

    // time limit
    initial
    begin
        #(64'd16_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial
    begin
        event_t directed[$];
        bit     effect;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        event_kind      <= EV_INIT;
        is_data_request <= 1'b0;
        rx_message_id   <= '0;
        rx_byte_one     <= '0;
        rx_byte_two     <= '0;
        rx_byte_ten     <= '0;
        rx_byte_eleven  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored events before init, retries, relay, data transfer, link test
        directed.push_back(make_event(EV_TX_REQ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_UNUSED_SEVEN, 1'b1, 8'd255, 8'd255, 8'd255,
                                      8'd255, 8'd255));
        directed.push_back(make_event(EV_INIT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_INIT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TX_REQ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TIMEOUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TIMEOUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TIMEOUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TX_REQ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TX_REQ, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, RST_ID_DATA_FIRST, 8'd0, 8'd0,
                                      8'd5, 8'd1));
        directed.push_back(make_event(EV_TIMEOUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, RST_ID_DATA_NEXT, 8'd5, 8'd3,
                                      8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TX_REQ, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, RST_ID_DATA_NEXT, 8'd255, 8'd255,
                                      8'd0, 8'd1));
        directed.push_back(make_event(EV_LINK_SETUP, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, RST_ID_PING, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_UNUSED_SIX, 1'b0, RST_ID_PING, 8'd0, 8'd0,
                                      8'd0, 8'd0));
        directed.push_back(make_event(EV_END_LINK, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TIMEOUT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_TX_REQ, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_event(EV_RX, 1'b0, RST_ID_DATA_FIRST, 8'd3, 8'd4,
                                      8'd0, 8'd0));
        foreach (directed[i])
            offer_event(directed[i], effect);
        in_valid <= 1'b0;

        // zero retry limit and extreme periods and ids, no idling
        program_regs(4'd0, 16'd0, 16'hFFFF, 8'd0, 8'd255, 8'd128);
        run_phase(70, 0, 0);

        // full retry limit, sender mostly idle
        program_regs(4'd15, 16'hFFFF, 16'd0, 8'd255, 8'd0, 8'd0);
        run_phase(70, 72, 0);

        // equal data ids, receiver mostly stalled
        program_regs(4'd3, 16'($urandom), 16'($urandom), 8'd7, 8'd7, 8'd255);
        run_phase(70, 0, 72);

        // light idling on both sides
        program_regs(4'd1, 16'd1234, 16'd4321, 8'd16, 8'd17, 8'd32);
        run_phase(70, 6, 6);

        // long receiver hold-off while requests keep coming
        hold_request = 1'b1;
        run_phase(30, 0, 0);

        // back to reset values
        program_regs(RST_RETRY_LIMIT, RST_SHORT_TIMEOUT, RST_LONG_TIMEOUT,
                     RST_ID_DATA_FIRST, RST_ID_DATA_NEXT, RST_ID_PING);
        run_phase(50, 6, 6);

        // drain and report
        wait_drained();
        repeat (4) @(posedge clk);
        if (board.expected_results.size() != 0)
            $error("%0d expected results never arrived", board.expected_results.size());
        if (board.error_count == 0 && board.expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
